// ----- rtl/core/mact_pkg.sv -----
// Shared types, widths and codes for the moving-average crossover trader.
`timescale 1ns / 1ps
`default_nettype none

package mact_pkg;

    localparam int PRICE_W   = 32;
    localparam int CAP_W     = 56;
    localparam int WIN_W     = 7;
    localparam int DAY_W     = 32;
    localparam int RET_W     = 32;
    localparam int EV_W      = 2;
    localparam int CFG_IDX_W = 2;

    // Divider geometry: remainder, divisor and quotient all fit in CAP_W bits.
    localparam int DIV_W     = CAP_W;
    localparam int STEP_W    = 6;
    localparam int HALF_W    = 28;
    localparam int MULP_W    = HALF_W + PRICE_W;
    localparam int D100_W    = 63;

    localparam logic [STEP_W-1:0] DIV_STEPS_BUY = 6'd56;
    localparam logic [STEP_W-1:0] DIV_STEPS_RET = 6'd32;

    localparam logic [CAP_W-1:0] CAP_MAX     = {CAP_W{1'b1}};
    localparam logic [DAY_W-1:0] DAY_MAX     = {DAY_W{1'b1}};
    localparam logic [RET_W-1:0] RET_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [RET_W-1:0] RET_NEG_MAX = 32'h8000_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CAPITAL = 2'd2;

    localparam logic [WIN_W-1:0] RST_SHORT_WINDOW    = 7'd20;
    localparam logic [WIN_W-1:0] RST_LONG_WINDOW     = 7'd50;
    localparam logic [CAP_W-1:0] RST_INITIAL_CAPITAL = 56'd6553600000;

    typedef enum logic [EV_W-1:0] {
        EV_NONE = 2'd0,
        EV_BUY  = 2'd1,
        EV_SELL = 2'd2
    } event_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DECIDE,
        ST_BUY_WAIT,
        ST_VAL_LO,
        ST_VAL_HI,
        ST_VAL_SUM,
        ST_RET_PREP,
        ST_RET_DIV,
        ST_RET_WAIT,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic sum_run;
        logic mul;
        logic buy_start;
        logic buy_commit;
        logic val_lo;
        logic val_hi;
        logic val_sum;
        logic sell_commit;
        logic ret_prep;
        logic ret_start;
        logic ret_fin;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic go_buy;
        logic go_sell;
        logic last;
        logic holding;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/mact_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by buy and return.
`timescale 1ns / 1ps
`default_nettype none

module mact_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [mact_pkg::DIV_W-1:0]  rem_init,
    input  wire logic [mact_pkg::DIV_W-1:0]  src,
    input  wire logic [mact_pkg::DIV_W-1:0]  divisor,
    input  wire logic [mact_pkg::STEP_W-1:0] steps,
    output logic                             busy,
    output logic [mact_pkg::DIV_W-1:0]       quotient
);
    import mact_pkg::*;

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  src_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [DIV_W:0]    trial;
    logic              fits;

    always_comb begin
        trial    = {rem_reg, src_reg[DIV_W-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            src_reg <= src;
            div_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            src_reg <= {src_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/mact_datapath.sv -----
// Datapath: price delay line, window sums, trade arithmetic and output register.
`timescale 1ns / 1ps
`default_nettype none

module mact_datapath #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire mact_pkg::ctrl_cmd_t              cmd,
    output mact_pkg::dp_status_t                  status,
    input  wire logic                             cfg_we,
    input  wire logic [mact_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mact_pkg::CAP_W-1:0]       cfg_wdata,
    input  wire logic [mact_pkg::PRICE_W-1:0]     s_price,
    input  wire logic                             s_last_sample,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [mact_pkg::EV_W-1:0]             m_event_res,
    output logic [mact_pkg::DAY_W-1:0]            m_day_number,
    output logic [mact_pkg::PRICE_W-1:0]          m_trade_price,
    output logic [mact_pkg::CAP_W-1:0]            m_account_value,
    output logic signed [mact_pkg::RET_W-1:0]     m_return_percent,
    output logic                                  m_is_final
);
    import mact_pkg::*;

    localparam int AW      = $clog2(MAX_WINDOW);
    localparam int SUM_W   = PRICE_W + $clog2(MAX_WINDOW + 1);
    localparam int PROD_W  = SUM_W + WIN_W;
    localparam int WIN_MAX = (MAX_WINDOW > (2 ** WIN_W) - 1) ? (2 ** WIN_W) - 1 : MAX_WINDOW;
    localparam logic [WIN_W-1:0] WIN_CAP  = WIN_W'(WIN_MAX);
    localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_WINDOW - 1);

    // Configuration registers
    logic [WIN_W-1:0] cfg_short_reg;
    logic [WIN_W-1:0] cfg_long_reg;
    logic [CAP_W-1:0] cfg_cap_reg;

    // Series state
    logic [PRICE_W-1:0] hist_mem [MAX_WINDOW];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [DAY_W-1:0]   count_reg;
    logic               holding_reg;
    logic [CAP_W-1:0]   cash_reg;
    logic [CAP_W-1:0]   share_reg;
    logic [CAP_W-1:0]   start_cap_reg;

    // Per-word working registers
    logic [PRICE_W-1:0] price_reg;
    logic               last_reg;
    logic [WIN_W-1:0]   k_reg;
    logic [WIN_W-1:0]   pend_k_reg;
    logic               pend_reg;
    logic [PRICE_W-1:0] rd_data_reg;
    logic [SUM_W-1:0]   short_sum_reg;
    logic [SUM_W-1:0]   long_sum_reg;
    logic [PROD_W-1:0]  lhs_reg;
    logic [PROD_W-1:0]  rhs_reg;
    logic [MULP_W-1:0]  lo_prod_reg;
    logic [MULP_W-1:0]  hi_prod_reg;
    logic [CAP_W-1:0]   value_reg;
    logic               neg_reg;
    logic [D100_W-1:0]  d100_reg;
    logic               buy_ovf_reg;
    logic               ret_ovf_reg;
    event_t             ev_reg;
    logic [RET_W-1:0]   ret_reg;

    // Output register
    logic               m_valid_reg;
    event_t             m_event_reg;
    logic [DAY_W-1:0]   m_day_reg;
    logic [PRICE_W-1:0] m_price_reg;
    logic [CAP_W-1:0]   m_acct_reg;
    logic [RET_W-1:0]   m_ret_reg;
    logic               m_final_reg;

    logic [WIN_W-1:0]   ll_c;
    logic [WIN_W-1:0]   sl_c;
    logic               issue;
    logic               in_series;
    logic [HALF_W-1:0]  mul_a;
    logic [MULP_W-1:0]  prod_c;
    logic [CAP_W:0]     val_sum_c;
    logic [CAP_W-1:0]   value_c;
    logic [CAP_W-1:0]   acct_c;
    logic               acct_below;
    logic [CAP_W-1:0]   diff_c;
    logic [D100_W-1:0]  d100_c;
    logic               div_busy;
    logic [DIV_W-1:0]   div_quo;
    logic               div_start;
    logic [DIV_W-1:0]   div_rem_init;
    logic [DIV_W-1:0]   div_src;
    logic [DIV_W-1:0]   div_divisor;
    logic [STEP_W-1:0]  div_steps;
    logic [RET_W-1:0]   ret_c;
    logic [RET_W-1:0]   quo_lo;

    // Window lengths: long is clamped to 1..min(MAX_WINDOW, 127), short to 1..long.
    always_comb begin
        if (cfg_long_reg == '0) begin
            ll_c = WIN_W'(1);
        end else if (cfg_long_reg > WIN_CAP) begin
            ll_c = WIN_CAP;
        end else begin
            ll_c = cfg_long_reg;
        end
        if (cfg_short_reg == '0) begin
            sl_c = WIN_W'(1);
        end else if (cfg_short_reg > ll_c) begin
            sl_c = ll_c;
        end else begin
            sl_c = cfg_short_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_short_reg <= RST_SHORT_WINDOW;
            cfg_long_reg  <= RST_LONG_WINDOW;
            cfg_cap_reg   <= RST_INITIAL_CAPITAL;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SHORT_WINDOW:    cfg_short_reg <= cfg_wdata[WIN_W-1:0];
                CFG_LONG_WINDOW:     cfg_long_reg  <= cfg_wdata[WIN_W-1:0];
                CFG_INITIAL_CAPITAL: cfg_cap_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Delay line: one write when a word arrives, one registered read per cycle while the sums are walked.
    assign issue = cmd.sum_run && (k_reg < ll_c);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hist_mem[wr_ptr_reg] <= s_price;
        end
        if (issue) begin
            rd_data_reg <= hist_mem[rd_ptr_reg];
        end
    end

    // Entries older than the current series are masked by the sample count.
    assign in_series = {{(DAY_W - WIN_W){1'b0}}, pend_k_reg} < count_reg;

    // Shared 28x32 multiplier for the two halves of the position value.
    always_comb begin
        mul_a     = cmd.val_lo ? share_reg[HALF_W-1:0] : share_reg[CAP_W-1:HALF_W];
        prod_c    = {{PRICE_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, price_reg};
        val_sum_c = {1'b0, hi_prod_reg[CAP_W-5:0], 4'b0000}
                  + {{(CAP_W + 1 - (MULP_W - 24)){1'b0}}, lo_prod_reg[MULP_W-1:24]};
        if ((hi_prod_reg[MULP_W-1:CAP_W-4] != '0) || val_sum_c[CAP_W]) begin
            value_c = CAP_MAX;
        end else begin
            value_c = val_sum_c[CAP_W-1:0];
        end
    end

    // Return preparation: |final - start| * 100.
    always_comb begin
        acct_c     = (last_reg && holding_reg) ? value_reg : cash_reg;
        acct_below = acct_c < start_cap_reg;
        diff_c     = acct_below ? (start_cap_reg - acct_c) : (acct_c - start_cap_reg);
        d100_c     = {1'b0, diff_c, 6'b0} + {2'b0, diff_c, 5'b0} + {5'b0, diff_c, 2'b0};
    end

    // Divider operands: buy divides cash * 2^24 by price, the return divides
    // |diff| * 100 * 2^16 by the start capital. Upper quotient bits are only
    // tested for overflow, so the remainder starts preloaded.
    always_comb begin
        div_start = cmd.buy_start || cmd.ret_start;
        if (cmd.buy_start) begin
            div_rem_init = {{(DIV_W - 24){1'b0}}, cash_reg[CAP_W-1:32]};
            div_src      = {cash_reg[31:0], 24'b0};
            div_divisor  = {{(DIV_W - PRICE_W){1'b0}}, price_reg};
            div_steps    = DIV_STEPS_BUY;
        end else begin
            div_rem_init = {{(DIV_W - (D100_W - 16)){1'b0}}, d100_reg[D100_W-1:16]};
            div_src      = {d100_reg[15:0], {(DIV_W - 16){1'b0}}};
            div_divisor  = start_cap_reg;
            div_steps    = DIV_STEPS_RET;
        end
    end

    mact_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem_init),
        .src      (div_src),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Saturated signed Q15.16 percent return.
    always_comb begin
        quo_lo = div_quo[RET_W-1:0];
        if (start_cap_reg == '0) begin
            ret_c = '0;
        end else if (!neg_reg) begin
            ret_c = (ret_ovf_reg || quo_lo[RET_W-1]) ? RET_POS_MAX : quo_lo;
        end else begin
            ret_c = (ret_ovf_reg || (quo_lo > RET_NEG_MAX)) ? RET_NEG_MAX : (RET_W'(0) - quo_lo);
        end
    end

    // Control state of the series
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            holding_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= issue;
            if (cmd.load) begin
                if (count_reg != DAY_MAX) begin
                    count_reg <= count_reg + 1'b1;
                end
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (cmd.buy_commit) begin
                holding_reg <= 1'b1;
            end
            if (cmd.sell_commit) begin
                holding_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                if (last_reg) begin
                    count_reg   <= '0;
                    holding_reg <= 1'b0;
                    wr_ptr_reg  <= '0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            price_reg     <= s_price;
            last_reg      <= s_last_sample;
            short_sum_reg <= {{(SUM_W - PRICE_W){1'b0}}, s_price};
            long_sum_reg  <= {{(SUM_W - PRICE_W){1'b0}}, s_price};
            k_reg         <= WIN_W'(1);
            rd_ptr_reg    <= (wr_ptr_reg == '0) ? LAST_IDX : wr_ptr_reg - 1'b1;
            ev_reg        <= EV_NONE;
            ret_reg       <= '0;
            if (count_reg == '0) begin
                cash_reg      <= cfg_cap_reg;
                start_cap_reg <= cfg_cap_reg;
            end
        end
        if (issue) begin
            k_reg      <= k_reg + 1'b1;
            pend_k_reg <= k_reg;
            rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_IDX : rd_ptr_reg - 1'b1;
        end
        if (pend_reg && in_series) begin
            long_sum_reg <= long_sum_reg + {{(SUM_W - PRICE_W){1'b0}}, rd_data_reg};
            if (pend_k_reg < sl_c) begin
                short_sum_reg <= short_sum_reg + {{(SUM_W - PRICE_W){1'b0}}, rd_data_reg};
            end
        end
        if (cmd.mul) begin
            lhs_reg <= {{WIN_W{1'b0}}, short_sum_reg} * {{SUM_W{1'b0}}, ll_c};
            rhs_reg <= {{WIN_W{1'b0}}, long_sum_reg} * {{SUM_W{1'b0}}, sl_c};
        end
        if (cmd.buy_start) begin
            buy_ovf_reg <= {{(PRICE_W - 24){1'b0}}, cash_reg[CAP_W-1:32]} >= price_reg;
        end
        if (cmd.buy_commit) begin
            share_reg <= buy_ovf_reg ? CAP_MAX : div_quo;
            cash_reg  <= '0;
            ev_reg    <= EV_BUY;
        end
        if (cmd.val_lo) begin
            lo_prod_reg <= prod_c;
        end
        if (cmd.val_hi) begin
            hi_prod_reg <= prod_c;
        end
        if (cmd.val_sum) begin
            value_reg <= value_c;
        end
        if (cmd.sell_commit) begin
            cash_reg <= value_c;
            ev_reg   <= EV_SELL;
        end
        if (cmd.ret_prep) begin
            neg_reg  <= acct_below;
            d100_reg <= d100_c;
        end
        if (cmd.ret_start) begin
            ret_ovf_reg <= {{(DIV_W - (D100_W - 16)){1'b0}}, d100_reg[D100_W-1:16]}
                           >= start_cap_reg;
        end
        if (cmd.ret_fin) begin
            ret_reg <= ret_c;
        end
        if (cmd.out_load) begin
            m_event_reg <= ev_reg;
            m_day_reg   <= count_reg;
            m_price_reg <= price_reg;
            m_acct_reg  <= acct_c;
            m_ret_reg   <= ret_reg;
            m_final_reg <= last_reg;
        end
    end

    always_comb begin
        status.sum_done = (k_reg >= ll_c) && !pend_reg;
        status.go_buy   = (count_reg > {{(DAY_W - WIN_W){1'b0}}, ll_c})
                       && (lhs_reg > rhs_reg) && !holding_reg;
        status.go_sell  = (count_reg > {{(DAY_W - WIN_W){1'b0}}, ll_c})
                       && (lhs_reg < rhs_reg) && holding_reg;
        status.last     = last_reg;
        status.holding  = holding_reg;
        status.div_busy = div_busy;
        status.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid          = m_valid_reg;
    assign m_event_res      = m_event_reg;
    assign m_day_number     = m_day_reg;
    assign m_trade_price    = m_price_reg;
    assign m_account_value  = m_acct_reg;
    assign m_return_percent = $signed(m_ret_reg);
    assign m_is_final       = m_final_reg;

endmodule

`default_nettype wire

// ----- rtl/core/mact_ctrl.sv -----
// Controller state machine sequencing one price word through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module mact_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire mact_pkg::dp_status_t status,
    output mact_pkg::ctrl_cmd_t       cmd
);
    import mact_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum_run = 1'b1;
                if (status.sum_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                priority if (status.go_buy) begin
                    cmd.buy_start = 1'b1;
                    state_next    = ST_BUY_WAIT;
                end else if (status.go_sell) begin
                    state_next = ST_VAL_LO;
                end else if (status.last) begin
                    state_next = status.holding ? ST_VAL_LO : ST_RET_PREP;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_BUY_WAIT: begin
                if (!status.div_busy) begin
                    cmd.buy_commit = 1'b1;
                    state_next     = status.last ? ST_VAL_LO : ST_OUT;
                end
            end
            ST_VAL_LO: begin
                cmd.val_lo = 1'b1;
                state_next = ST_VAL_HI;
            end
            ST_VAL_HI: begin
                cmd.val_hi = 1'b1;
                state_next = ST_VAL_SUM;
            end
            ST_VAL_SUM: begin
                cmd.val_sum = 1'b1;
                if (status.go_sell) begin
                    cmd.sell_commit = 1'b1;
                    state_next      = status.last ? ST_RET_PREP : ST_OUT;
                end else begin
                    state_next = ST_RET_PREP;
                end
            end
            ST_RET_PREP: begin
                cmd.ret_prep = 1'b1;
                state_next   = ST_RET_DIV;
            end
            ST_RET_DIV: begin
                cmd.ret_start = 1'b1;
                state_next    = ST_RET_WAIT;
            end
            ST_RET_WAIT: begin
                if (!status.div_busy) begin
                    cmd.ret_fin = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/ma_crossover_trade_signal.sv -----
// Top level of the dual moving-average crossover trader: controller plus datapath.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   s_      | in        | s_valid / s_ready  | s_price, s_last_sample
//   m_      | out       | m_valid / m_ready  | m_event_res, m_day_number, m_trade_price,
//           |           |                    | m_account_value, m_return_percent, m_is_final
//   cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// Each input word re-forms the window sums by walking the delay line through its single
// read port, across the clamped long window. A buy adds a pass through the shared radix-2
// divider, a sell adds two passes over one 28x32 multiplier, and the last word of a series
// adds a return divide.
// Reset is synchronous and active low; no memory clearing pass is needed after it.
// A result waiting in the output register does not block the next input word; only the
// hand-off of a new result waits for m_ready.
`timescale 1ns / 1ps
`default_nettype none

module ma_crossover_trade_signal #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_we,
    input  wire logic [mact_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mact_pkg::CAP_W-1:0]      cfg_wdata,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [mact_pkg::PRICE_W-1:0]    s_price,
    input  wire logic                            s_last_sample,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [mact_pkg::EV_W-1:0]            m_event_res,
    output logic [mact_pkg::DAY_W-1:0]           m_day_number,
    output logic [mact_pkg::PRICE_W-1:0]         m_trade_price,
    output logic [mact_pkg::CAP_W-1:0]           m_account_value,
    output logic signed [mact_pkg::RET_W-1:0]    m_return_percent,
    output logic                                 m_is_final
);
    import mact_pkg::*;

    // Apart from the input handshake, the controller only sees status flags and only drives command strobes.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    mact_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the configuration registers, the price delay line,
    // the account state, the shared divider and the output word register.
    mact_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_price          (s_price),
        .s_last_sample    (s_last_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_day_number     (m_day_number),
        .m_trade_price    (m_trade_price),
        .m_account_value  (m_account_value),
        .m_return_percent (m_return_percent),
        .m_is_final       (m_is_final)
    );

`ifndef SYNTHESIS
    // Only one word is in work at a time.
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input word accepted while another is in work");

    // A new result never overwrites one that has not been taken.
    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output word overwritten before hand-off");

    // Buys only happen flat, sells only while holding.
    a_buy_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.buy_commit |-> !status.holding)
        else $error("buy committed while holding a position");

    a_sell_held: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sell_commit |-> status.holding)
        else $error("sell committed with no position");
`endif

endmodule

`default_nettype wire
